@@ rtl/core/sll_pkg.sv @@
// Package for the small language lexer: scan state, token record and token codes.
// Character class and keyword helpers used by the scanner.
// No dependencies.
`timescale 1ns / 1ps

package sll_pkg;

  localparam int LEN_BITS     = 6;
  localparam int START_BITS   = 16;
  localparam int PREFIX_BYTES = 5;
  localparam int TOK_SLOTS    = 3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_OPER,
    MODE_COMMENT,
    MODE_DONE
  } scan_mode_t;

  typedef enum logic [5:0] {
    TK_DECLARE_INT, TK_DECLARE_FLOAT, TK_ASSIGN, TK_NUMBER, TK_PLUS, TK_MINUS,
    TK_MULTIPLY, TK_RAISE, TK_DIVIDE, TK_CMP_MORE, TK_CMP_LESS, TK_CMP_MORE_EQUAL,
    TK_CMP_LESS_EQUAL, TK_CMP_EQL, TK_CMP_NOT_EQUAL, TK_CMP_NOT, TK_IF, TK_WHILE,
    TK_PRINT, TK_SEMICOLON, TK_ID, TK_END, TK_L_PAREN, TK_R_PAREN, TK_L_CURLY,
    TK_R_CURLY, TK_EXECUTE, TK_NEW_LINE, TK_ADD_ASSIGN, TK_SUB_ASSIGN,
    TK_MULT_ASSIGN, TK_DIV_ASSIGN, TK_AND, TK_OR, TK_INVALID
  } token_kind_t;

  typedef struct packed {
    scan_mode_t                  mode;
    logic [7:0]                  held;
    logic [8*PREFIX_BYTES-1:0]   prefix;
    logic [LEN_BITS-1:0]         len;
    logic                        dot;
    logic                        inval;
  } scan_state_t;

  typedef struct packed {
    token_kind_t           kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   len;
    logic                  stream_end;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_holdable(input logic [7:0] c);
    return c == "=" || c == ">" || c == "<" || c == "!" ||
           c == "+" || c == "-" || c == "*" || c == "/";
  endfunction

  function automatic token_kind_t pair_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      "=":     k = TK_CMP_EQL;
      ">":     k = TK_CMP_MORE_EQUAL;
      "<":     k = TK_CMP_LESS_EQUAL;
      "!":     k = TK_CMP_NOT_EQUAL;
      "+":     k = TK_ADD_ASSIGN;
      "-":     k = TK_SUB_ASSIGN;
      "*":     k = TK_MULT_ASSIGN;
      default: k = TK_DIV_ASSIGN;
    endcase
    return k;
  endfunction

  function automatic token_kind_t single_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      "=":     k = TK_ASSIGN;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_MULTIPLY;
      "^":     k = TK_RAISE;
      "/":     k = TK_DIVIDE;
      ">":     k = TK_CMP_MORE;
      "<":     k = TK_CMP_LESS;
      "!":     k = TK_CMP_NOT;
      "(":     k = TK_L_PAREN;
      ")":     k = TK_R_PAREN;
      "{":     k = TK_L_CURLY;
      "}":     k = TK_R_CURLY;
      ";":     k = TK_SEMICOLON;
      8'h0a:   k = TK_NEW_LINE;
      default: k = TK_INVALID;
    endcase
    return k;
  endfunction

  // Keywords are at most five characters, so the stored prefix settles them.
  function automatic token_kind_t word_kind(input logic [8*PREFIX_BYTES-1:0] p,
                                            input logic [LEN_BITS-1:0] len);
    logic [7:0] b0, b1, b2, b3, b4;
    token_kind_t k;
    b0 = p[7:0];
    b1 = p[15:8];
    b2 = p[23:16];
    b3 = p[31:24];
    b4 = p[39:32];
    k = TK_ID;
    if (len == LEN_BITS'(3) && b0 == "i" && b1 == "n" && b2 == "t") begin
      k = TK_DECLARE_INT;
    end else if (len == LEN_BITS'(5) && b0 == "f" && b1 == "l" && b2 == "o" &&
                 b3 == "a" && b4 == "t") begin
      k = TK_DECLARE_FLOAT;
    end else if (len == LEN_BITS'(2) && b0 == "i" && b1 == "f") begin
      k = TK_IF;
    end else if (len == LEN_BITS'(5) && b0 == "w" && b1 == "h" && b2 == "i" &&
                 b3 == "l" && b4 == "e") begin
      k = TK_WHILE;
    end else if (len == LEN_BITS'(5) && b0 == "p" && b1 == "r" && b2 == "i" &&
                 b3 == "n" && b4 == "t") begin
      k = TK_PRINT;
    end else if (len == LEN_BITS'(3) && b0 == "a" && b1 == "n" && b2 == "d") begin
      k = TK_AND;
    end else if (len == LEN_BITS'(2) && b0 == "o" && b1 == "r") begin
      k = TK_OR;
    end
    return k;
  endfunction

  function automatic token_t make_tok(input token_kind_t kind,
                                      input logic [START_BITS-1:0] start,
                                      input logic [LEN_BITS-1:0] len,
                                      input logic stream_end);
    token_t t;
    t.kind       = kind;
    t.start      = start;
    t.len        = len;
    t.stream_end = stream_end;
    return t;
  endfunction

endpackage

@@ rtl/core/small_language_lexer.sv @@
// Top level of the small language lexer: scan state registers and token buffer.
// Depends on sll_pkg and sll_scan.
`timescale 1ns / 1ps

// The lexer takes one source byte per cycle while src_ready is high and emits
// tokens (kind, start offset, length, end-of-stream flag) via a three-entry
// result buffer. A byte is scanned in the cycle it is accepted; its tokens
// are in the buffer on the next cycle. src_ready is high when the buffer is
// empty or its last token is being taken, so with tok_ready held high a byte
// with at most one token never holds up the next, and one with two or three
// holds the next off while the buffer drains. After an error token, bytes
// are still accepted and dropped until the one marked final_byte.

module small_language_lexer
  import sll_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 49,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  logic [7:0]            source_byte,
  input  logic                  final_byte,
  output logic                  tok_valid,
  input  logic                  tok_ready,
  output logic [5:0]            token_kind,
  output logic [START_BITS-1:0] token_start,
  output logic [LEN_BITS-1:0]   token_length,
  output logic                  stream_end
);

  scan_state_t              st;
  logic [POSITION_BITS-1:0] cur_start;
  logic [POSITION_BITS-1:0] cur_pos;

  scan_state_t              st_next;
  logic [POSITION_BITS-1:0] cur_start_next;
  logic [POSITION_BITS-1:0] cur_pos_next;
  token_t [TOK_SLOTS-1:0]   new_toks;
  logic [1:0]               new_count;

  token_t [TOK_SLOTS-1:0]   slots;
  logic [1:0]               rd_ptr;
  logic [1:0]               count;
  token_t                   head;
  logic                     src_take;
  logic                     tok_take;

  sll_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .cur         (st),
    .cur_start   (cur_start),
    .cur_pos     (cur_pos),
    .source_byte (source_byte),
    .final_byte  (final_byte),
    .nxt         (st_next),
    .nxt_start   (cur_start_next),
    .nxt_pos     (cur_pos_next),
    .toks        (new_toks),
    .tok_count   (new_count)
  );

  assign tok_valid = (count != 2'd0);
  assign tok_take  = tok_valid && tok_ready;
  assign src_ready = (count == 2'd0) || (count == 2'd1 && tok_ready);
  assign src_take  = src_valid && src_ready;

  // All-zero state is the idle mode with nothing pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      cur_start <= '0;
      cur_pos   <= '0;
    end else if (src_take) begin
      st        <= st_next;
      cur_start <= cur_start_next;
      cur_pos   <= cur_pos_next;
    end
  end

  // A new transaction is taken only when the buffer drains this cycle, so the
  // new tokens always refill it from slot zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      count  <= '0;
    end else if (src_take) begin
      rd_ptr <= '0;
      count  <= new_count;
    end else if (tok_take) begin
      rd_ptr <= rd_ptr + 2'd1;
      count  <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      slots <= new_toks;
    end
  end

  always_comb begin
    case (rd_ptr)
      2'd0:    head = slots[0];
      2'd1:    head = slots[1];
      default: head = slots[2];
    endcase
  end

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.len;
  assign stream_end   = head.stream_end;

endmodule

@@ rtl/core/sll_scan.sv @@
// Single-byte scan step: from the current scan state and one source byte, the
// next state and the zero to three tokens that the byte produces.
// Depends on sll_pkg.
`timescale 1ns / 1ps

module sll_scan
  import sll_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 49,
  parameter int POSITION_BITS = 16
) (
  input  scan_state_t                   cur,
  input  logic [POSITION_BITS-1:0]      cur_start,
  input  logic [POSITION_BITS-1:0]      cur_pos,
  input  logic [7:0]                    source_byte,
  input  logic                          final_byte,
  output scan_state_t                   nxt,
  output logic [POSITION_BITS-1:0]      nxt_start,
  output logic [POSITION_BITS-1:0]      nxt_pos,
  output token_t [TOK_SLOTS-1:0]        toks,
  output logic [1:0]                    tok_count
);

  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);

  logic [7:0] c;
  logic       alnum;
  logic       start_new;
  logic [1:0] cnt;

  assign c     = source_byte;
  assign alnum = is_letter(source_byte) || is_digit(source_byte);

  function automatic scan_state_t append_byte(input scan_state_t s, input logic [7:0] b);
    scan_state_t r;
    r = s;
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      if (s.len == LEN_BITS'(i)) begin
        r.prefix[8*i +: 8] = b;
      end
    end
    r.len = s.len + LEN_BITS'(1);
    return r;
  endfunction

  always_comb begin
    nxt       = cur;
    nxt_start = cur_start;
    nxt_pos   = cur_pos;
    toks      = '0;
    cnt       = '0;
    start_new = 1'b0;

    if (cur.mode != MODE_DONE) begin
      case (cur.mode)
        MODE_WORD: begin
          if (alnum) begin
            if (cur.len >= LEN_MAX) begin
              toks[cnt] = make_tok(TK_INVALID, START_BITS'(cur_start), LEN_MAX, 1'b1);
              cnt       = cnt + 2'd1;
              nxt.mode  = MODE_DONE;
            end else begin
              nxt = append_byte(cur, c);
            end
          end else begin
            toks[cnt] = make_tok(word_kind(cur.prefix, cur.len), START_BITS'(cur_start),
                                 cur.len, 1'b0);
            cnt       = cnt + 2'd1;
            nxt.mode  = MODE_IDLE;
            start_new = 1'b1;
          end
        end
        MODE_NUM: begin
          if (alnum || c == ".") begin
            if (cur.len >= LEN_MAX) begin
              toks[cnt] = make_tok(TK_INVALID, START_BITS'(cur_start), LEN_MAX, 1'b1);
              cnt       = cnt + 2'd1;
              nxt.mode  = MODE_DONE;
            end else begin
              nxt = append_byte(cur, c);
              if (is_letter(c)) begin
                nxt.inval = 1'b1;
              end else if (c == ".") begin
                nxt.inval = cur.inval | cur.dot;
                nxt.dot   = 1'b1;
              end
            end
          end else if (cur.inval) begin
            toks[cnt] = make_tok(TK_INVALID, START_BITS'(cur_start), cur.len, 1'b1);
            cnt       = cnt + 2'd1;
            nxt.mode  = MODE_DONE;
          end else begin
            toks[cnt] = make_tok(TK_NUMBER, START_BITS'(cur_start), cur.len, 1'b0);
            cnt       = cnt + 2'd1;
            nxt.mode  = MODE_IDLE;
            start_new = 1'b1;
          end
        end
        MODE_OPER: begin
          if (c == "=") begin
            toks[cnt] = make_tok(pair_kind(cur.held), START_BITS'(cur_start),
                                 LEN_BITS'(2), 1'b0);
            cnt       = cnt + 2'd1;
            nxt.mode  = MODE_IDLE;
          end else if (cur.held == "/" && c == "/") begin
            nxt.mode = MODE_COMMENT;
          end else begin
            toks[cnt] = make_tok(single_kind(cur.held), START_BITS'(cur_start),
                                 LEN_BITS'(1), 1'b0);
            cnt       = cnt + 2'd1;
            nxt.mode  = MODE_IDLE;
            start_new = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == 8'h0a) begin
            nxt.mode  = MODE_IDLE;
            start_new = 1'b1;
          end
        end
        MODE_IDLE: begin
          start_new = 1'b1;
        end
        default: begin
          nxt.mode = MODE_DONE;
        end
      endcase

      // The byte opens something new once the previous token has closed.
      if (start_new && c != " ") begin
        if (is_letter(c) || is_digit(c) || c == "." || is_holdable(c)) begin
          nxt_start  = cur_pos;
          nxt.len    = '0;
          nxt.prefix = '0;
          nxt.dot    = 1'b0;
          nxt.inval  = 1'b0;
          if (is_letter(c)) begin
            nxt.mode = MODE_WORD;
            nxt      = append_byte(nxt, c);
          end else if (is_holdable(c)) begin
            nxt.mode = MODE_OPER;
            nxt.held = c;
          end else begin
            nxt.mode = MODE_NUM;
            nxt.dot  = (c == ".");
            nxt      = append_byte(nxt, c);
          end
        end else if (single_kind(c) == TK_INVALID) begin
          toks[cnt] = make_tok(TK_INVALID, START_BITS'(cur_pos), LEN_BITS'(1), 1'b1);
          cnt       = cnt + 2'd1;
          nxt.mode  = MODE_DONE;
        end else begin
          toks[cnt] = make_tok(single_kind(c), START_BITS'(cur_pos), LEN_BITS'(1), 1'b0);
          cnt       = cnt + 2'd1;
        end
      end

      nxt_pos = (cur_pos == '1) ? cur_pos : cur_pos + POSITION_BITS'(1);

      // On the last byte, flush whatever is still open and close the stream.
      if (final_byte && nxt.mode != MODE_DONE) begin
        case (nxt.mode)
          MODE_WORD: begin
            toks[cnt] = make_tok(word_kind(nxt.prefix, nxt.len), START_BITS'(nxt_start),
                                 nxt.len, 1'b0);
            cnt       = cnt + 2'd1;
          end
          MODE_NUM: begin
            if (nxt.inval) begin
              toks[cnt] = make_tok(TK_INVALID, START_BITS'(nxt_start), nxt.len, 1'b1);
              cnt       = cnt + 2'd1;
              nxt.mode  = MODE_DONE;
            end else begin
              toks[cnt] = make_tok(TK_NUMBER, START_BITS'(nxt_start), nxt.len, 1'b0);
              cnt       = cnt + 2'd1;
            end
          end
          MODE_OPER: begin
            toks[cnt] = make_tok(single_kind(nxt.held), START_BITS'(nxt_start),
                                 LEN_BITS'(1), 1'b0);
            cnt       = cnt + 2'd1;
          end
          default: begin
          end
        endcase
        if (nxt.mode != MODE_DONE) begin
          toks[cnt] = make_tok(TK_END, START_BITS'(nxt_pos), '0, 1'b1);
          cnt       = cnt + 2'd1;
        end
      end
    end

    if (final_byte) begin
      nxt       = '0;
      nxt.mode  = MODE_IDLE;
      nxt_start = '0;
      nxt_pos   = '0;
    end
  end

  assign tok_count = cnt;

endmodule

@@ rtl/core/sll_checker.sv @@
// Port-level checks for the small language lexer, bound to the top level.
// Depends on sll_pkg and small_language_lexer.
`timescale 1ns / 1ps

module sll_checker
  import sll_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  tok_valid,
  input logic                  tok_ready,
  input logic [5:0]            token_kind,
  input logic [START_BITS-1:0] token_start,
  input logic [LEN_BITS-1:0]   token_length,
  input logic                  stream_end
);

  // A stalled token must hold until the transaction completes.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) &&
      $stable(token_start) && $stable(token_length) && $stable(stream_end))
    else $error("token changed while stalled");

  a_end_form: assert property (@(posedge clk) disable iff (rst)
    tok_valid && token_kind == TK_END |-> stream_end && token_length == '0)
    else $error("END token without end flag or with nonzero length");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    tok_valid && stream_end |-> token_kind == TK_END || token_kind == TK_INVALID)
    else $error("end flag on a token that does not close the stream");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !stream_end |-> token_length != '0)
    else $error("ordinary token with zero length");

endmodule

bind small_language_lexer sll_checker u_sll_checker (
  .clk          (clk),
  .rst          (rst),
  .tok_valid    (tok_valid),
  .tok_ready    (tok_ready),
  .token_kind   (token_kind),
  .token_start  (token_start),
  .token_length (token_length),
  .stream_end   (stream_end)
);
